>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

>>> sv/i8bup_pkg.sv
// ----------------------------------------------------------------------------
// i8bup_pkg
// types and constants of the packed int8 b-matrix unpack address generator
// ----------------------------------------------------------------------------
`default_nettype none

package i8bup_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_W      = 16;          // nc, kc, ld, column base
  localparam int KG_W       = 14;          // k-group index
  localparam int KGRP_W     = KG_W + 1;    // number of k-groups
  localparam int N_W        = DIM_W + 1;   // column index may pass 16 bits
  localparam int SUM_W      = N_W + DIM_W + 1;
  localparam int DEST_W     = 32;
  localparam int BYTE_W     = 8;

  localparam logic [DIM_W-1:0] SUB_PANEL = 16'd16;
  localparam logic [DIM_W-1:0] SUB_MASK  = 16'hFFF0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLUMNS  = 4'd0,
    REG_DEPTH_K      = 4'd1,
    REG_LEADING_DIM  = 4'd2,
    REG_COLUMN_MAJOR = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] num_columns;
    logic [DIM_W-1:0] depth_k;
    logic [DIM_W-1:0] leading_dim;
    logic             column_major;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    num_columns:  16'd64,
    depth_k:      16'd4,
    leading_dim:  16'd64,
    column_major: 1'b0
  };

  // position of the current byte, from the buffer walk
  typedef struct packed {
    logic [DIM_W-1:0] k;
    logic [N_W-1:0]   n;
    logic             write_enable;
    logic             last_byte;
  } walk_pos_t;

  // operands held between the input register and the result register
  typedef struct packed {
    logic [N_W-1:0]           mul_a;
    logic [N_W-1:0]           addend;
    logic signed [BYTE_W-1:0] value;
    logic                     write_enable;
    logic                     last_byte;
  } mac_op_t;

endpackage

`default_nettype wire

>>> sv/i8bup_if.sv
// ----------------------------------------------------------------------------
// i8bup_if
// valid/ready channel interfaces: byte input, result output, register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface i8bup_in_if import i8bup_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [BYTE_W-1:0] packed_byte;

  modport source (output valid, output packed_byte, input ready);
  modport sink   (input valid, input packed_byte, output ready);
endinterface

interface i8bup_out_if import i8bup_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DEST_W-1:0]        dest_addr;
  logic signed [BYTE_W-1:0] out_value;
  logic                     write_enable;
  logic                     last_byte;

  modport source (output valid, output dest_addr, output out_value,
                  output write_enable, output last_byte, input ready);
  modport sink   (input valid, input dest_addr, input out_value,
                  input write_enable, input last_byte, output ready);
endinterface

interface i8bup_cfg_if import i8bup_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/int8_gemm_b_unpack_addr_gen_top.sv
// ----------------------------------------------------------------------------
// int8_gemm_b_unpack_addr_gen_top
// destination addresses for the bytes of a packed int8 b matrix
// ----------------------------------------------------------------------------
// usage:
//   in_i   takes the packed buffer one signed byte per item, in buffer order
//   out_o  gives one item per input byte: destination element offset, the
//          byte itself, write enable (0 on padding bytes) and an end mark on
//          the final byte of the buffer
//   cfg_i  writes num_columns, depth_k, leading_dim, column_major by index;
//          always ready, write only while no item is in flight; a write to a
//          known index restarts the walk at the first byte of the buffer
//   a byte accepted on in_i passes the input register, then the multiply-add
//   into the result register, before its result is valid on out_o
//   throughput: one byte per cycle unless out_o stalls, one multiply-add stage
//   after the last byte the walk wraps to the start of a new buffer
//   reset: configuration returns to 64 columns, depth 4, leading dim 64,
//          row-major; both stages are emptied
//   a stalled receiver holds the result; the input register still takes one
//   more byte if it is empty, then in_i.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module int8_gemm_b_unpack_addr_gen_top
  import i8bup_pkg::*;
#(
  parameter int PANEL_COLS = 64,
  parameter int ADDR_BITS  = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  i8bup_in_if.sink    in_i,
  i8bup_out_if.source out_o,
  i8bup_cfg_if.sink   cfg_i
);

  cfg_t      cfg, cfg_next;
  logic      restart;
  logic      in_ready;
  walk_pos_t pos;

  i8bup_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .cfg_o      (cfg),
    .cfg_next_o (cfg_next),
    .restart_o  (restart)
  );

  i8bup_walk #(
    .PANEL_COLS (PANEL_COLS)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cfg_next_i (cfg_next),
    .restart_i  (restart),
    .advance_i  (in_i.valid && in_ready),
    .pos_o      (pos)
  );

  i8bup_addr #(
    .ADDR_BITS (ADDR_BITS)
  ) u_addr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_ready),
    .in_value_i     (in_i.packed_byte),
    .pos_i          (pos),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .dest_addr_o    (out_o.dest_addr),
    .out_value_o    (out_o.out_value),
    .write_enable_o (out_o.write_enable),
    .last_byte_o    (out_o.last_byte)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

>>> sv/i8bup_cfg.sv
// ----------------------------------------------------------------------------
// i8bup_cfg
// configuration registers; any known write restarts the buffer walk
// ----------------------------------------------------------------------------
`default_nettype none

module i8bup_cfg
  import i8bup_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  i8bup_cfg_if.sink  cfg_i,
  output cfg_t       cfg_o,
  output cfg_t       cfg_next_o,
  output logic       restart_o
);

  cfg_t cfg_q, cfg_d;
  logic hit;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_NUM_COLUMNS: begin
          cfg_d.num_columns = cfg_i.data;
          hit = 1'b1;
        end
        REG_DEPTH_K: begin
          cfg_d.depth_k = cfg_i.data;
          hit = 1'b1;
        end
        REG_LEADING_DIM: begin
          cfg_d.leading_dim = cfg_i.data;
          hit = 1'b1;
        end
        REG_COLUMN_MAJOR: begin
          cfg_d.column_major = cfg_i.data[0];
          hit = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign cfg_next_o = cfg_d;
  assign restart_o  = hit;

endmodule

`default_nettype wire

>>> sv/i8bup_walk.sv
// ----------------------------------------------------------------------------
// i8bup_walk
// buffer walk counters: byte in column, column in panel, k-group, panel base
// ----------------------------------------------------------------------------
`default_nettype none

module i8bup_walk
  import i8bup_pkg::*;
#(
  parameter int PANEL_COLS = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  input  cfg_t       cfg_next_i,
  input  wire logic  restart_i,
  input  wire logic  advance_i,
  output walk_pos_t  pos_o
);

  localparam int COL_W = $clog2(PANEL_COLS);
  localparam int PW_W  = $clog2(PANEL_COLS + 1);

  // width of the sub-panel that starts at column base
  function automatic logic [PW_W-1:0] width_from(input logic [DIM_W-1:0] nc,
                                                 input logic [DIM_W-1:0] base);
    logic [DIM_W-1:0] rest;
    rest = (base < nc) ? (nc - base) : '0;
    if (rest >= DIM_W'(PANEL_COLS)) begin
      width_from = PW_W'(PANEL_COLS);
    end else if (rest >= SUB_PANEL) begin
      width_from = PW_W'(rest & SUB_MASK);
    end else begin
      width_from = PW_W'(SUB_PANEL);
    end
  endfunction

  logic [DIM_W-1:0] base_q, base_d;
  logic [PW_W-1:0]  pw_q, pw_d;
  logic [KG_W-1:0]  kg_q, kg_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [1:0]       bic_q, bic_d;

  logic [DIM_W:0]    kc_p3;
  logic [KGRP_W-1:0] groups;
  logic [DIM_W:0]    base_end;
  logic              last_bic, last_col, last_group, last_panel;

  always_comb begin
    kc_p3  = {1'b0, cfg_i.depth_k} + (DIM_W + 1)'(3);
    groups = kc_p3[DIM_W:2];
    if (groups == '0) begin
      groups = KGRP_W'(1);
    end
    base_end   = {1'b0, base_q} + (DIM_W + 1)'(pw_q);
    last_bic   = &bic_q;
    last_col   = (PW_W'(col_q) + PW_W'(1)) >= pw_q;
    last_group = ({1'b0, kg_q} + KGRP_W'(1)) >= groups;
    last_panel = base_end >= {1'b0, cfg_i.num_columns};

    pos_o.k            = {kg_q, bic_q};
    pos_o.n            = {1'b0, base_q} + N_W'(col_q);
    pos_o.write_enable = (pos_o.k < cfg_i.depth_k) &&
                         (pos_o.n < {1'b0, cfg_i.num_columns});
    pos_o.last_byte    = last_panel && last_group && last_col && last_bic;
  end

  always_comb begin
    base_d = base_q;
    pw_d   = pw_q;
    kg_d   = kg_q;
    col_d  = col_q;
    bic_d  = bic_q;
    if (restart_i) begin
      base_d = '0;
      pw_d   = width_from(cfg_next_i.num_columns, '0);
      kg_d   = '0;
      col_d  = '0;
      bic_d  = '0;
    end else if (advance_i) begin
      bic_d = bic_q + 2'd1;
      if (last_bic) begin
        col_d = col_q + COL_W'(1);
        if (last_col) begin
          col_d = '0;
          kg_d  = kg_q + KG_W'(1);
          if (last_group) begin
            kg_d = '0;
            if (last_panel) begin
              base_d = '0;
              pw_d   = width_from(cfg_i.num_columns, '0);
            end else begin
              base_d = base_end[DIM_W-1:0];
              pw_d   = width_from(cfg_i.num_columns, base_end[DIM_W-1:0]);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      pw_q   <= width_from(CFG_RESET.num_columns, '0);
      kg_q   <= '0;
      col_q  <= '0;
      bic_q  <= '0;
    end else begin
      base_q <= base_d;
      pw_q   <= pw_d;
      kg_q   <= kg_d;
      col_q  <= col_d;
      bic_q  <= bic_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/i8bup_addr.sv
// ----------------------------------------------------------------------------
// i8bup_addr
// input register, multiply-add of the destination address, result register
// ----------------------------------------------------------------------------
`default_nettype none

module i8bup_addr
  import i8bup_pkg::*;
#(
  parameter int ADDR_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  cfg_t                          cfg_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [BYTE_W-1:0] in_value_i,
  input  walk_pos_t                     pos_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [DEST_W-1:0]             dest_addr_o,
  output logic signed [BYTE_W-1:0]      out_value_o,
  output logic                          write_enable_o,
  output logic                          last_byte_o
);

  localparam logic [SUM_W-1:0] ADDR_MASK = SUM_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic    s1_valid_q;
  mac_op_t s1_q, s1_d;
  logic    s1_ready, s2_ready;

  logic                     out_valid_q;
  logic [DEST_W-1:0]        dest_q, dest_d;
  logic signed [BYTE_W-1:0] value_q;
  logic                     we_q, last_q;
  logic [SUM_W-1:0]         sum;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // column-major swaps which index scales with the leading dimension
  always_comb begin
    s1_d.mul_a        = cfg_i.column_major ? pos_i.n : N_W'(pos_i.k);
    s1_d.addend       = cfg_i.column_major ? N_W'(pos_i.k) : pos_i.n;
    s1_d.value        = in_value_i;
    s1_d.write_enable = pos_i.write_enable;
    s1_d.last_byte    = pos_i.last_byte;
  end

  always_comb begin
    sum    = SUM_W'(SUM_W'(s1_q.mul_a) * SUM_W'(cfg_i.leading_dim)) + SUM_W'(s1_q.addend);
    dest_d = DEST_W'(sum & ADDR_MASK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s2_ready) begin
      dest_q  <= dest_d;
      value_q <= s1_q.value;
      we_q    <= s1_q.write_enable;
      last_q  <= s1_q.last_byte;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_addr_o    = dest_q;
  assign out_value_o    = value_q;
  assign write_enable_o = we_q;
  assign last_byte_o    = last_q;

endmodule

`default_nettype wire

>>> sv/i8bup_checker.sv
// ----------------------------------------------------------------------------
// i8bup_checker
// port-level checks of the unpack address generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i8bup_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] dest_addr_i,
  input wire logic [7:0]  out_value_i,
  input wire logic        write_enable_i,
  input wire logic        last_byte_i
);

  logic        in_acc;
  logic        out_stall;
  logic [41:0] out_payload;

  assign in_acc      = in_valid_i && in_ready_i;
  assign out_stall   = out_valid_i && !out_ready_i;
  assign out_payload = {dest_addr_i, out_value_i, write_enable_i, last_byte_i};

  // a stalled result keeps its payload
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i && $stable(out_payload))

  // input side only backs up when both stages are full and the output stalls
  `ASSERT_NEVER(a_ready_drop, clk_i, rst_ni, !in_ready_i && !out_stall)

  // an empty output fills from a byte that passed the input register, then the result register
  `ASSERT_CLK(a_fill_latency, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_acc, 2))

endmodule

bind int8_gemm_b_unpack_addr_gen_top i8bup_checker u_i8bup_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .dest_addr_i    (out_o.dest_addr),
  .out_value_i    (out_o.out_value),
  .write_enable_i (out_o.write_enable),
  .last_byte_i    (out_o.last_byte)
);

`default_nettype wire
